// ===== rtl/assert_macros.svh =====
// Shared assertion helpers; clock and reset names follow the project ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SCP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scp_pkg.sv =====
package scp_pkg;

    localparam int VW       = 32;
    localparam int KW_COUNT = 6;

    localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] VAL_MAX = ~VAL_MIN;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    // Keyword indexes
    localparam int KW_IDN   = 0;
    localparam int KW_MEASQ = 1;
    localparam int KW_MQ    = 2;
    localparam int KW_MEASR = 3;
    localparam int KW_MS    = 4;
    localparam int KW_SET   = 5;

    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{8'h2A, 8'h49, 8'h44, 8'h4E, 8'h3F, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h45, 8'h41, 8'h53, 8'h55, 8'h52, 8'h45, 8'h3F},
        '{8'h4D, 8'h45, 8'h41, 8'h53, 8'h3F, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h45, 8'h41, 8'h53, 8'h55, 8'h52, 8'h45, 8'h00},
        '{8'h4D, 8'h45, 8'h41, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd5, 4'd8, 4'd5, 4'd7, 4'd4, 4'd3};

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_SIGN  = 3'd1,
        PH_ZERO  = 3'd2,
        PH_HEXP  = 3'd3,
        PH_HEX   = 3'd4,
        PH_OCT   = 3'd5,
        PH_DEC   = 3'd6,
        PH_DONE  = 3'd7
    } t_nphase;

    typedef enum logic [1:0] {
        BASE_8  = 2'd0,
        BASE_10 = 2'd1,
        BASE_16 = 2'd2
    } t_base;

    typedef enum logic [1:0] {
        GS_IDLE     = 2'd0,
        GS_SET      = 2'd1,
        GS_SET_MEAS = 2'd2
    } t_gstate;

    typedef enum logic [2:0] {
        EV_IDN         = 3'd0,
        EV_MEAS_REPORT = 3'd1,
        EV_MEAS_SET    = 3'd2,
        EV_SYNTAX      = 3'd3,
        EV_UNKNOWN     = 3'd4
    } t_event;

    // Classified token handed from front to back
    typedef struct packed {
        logic          idn;
        logic          measq;
        logic          set;
        logic          meas;
        logic          num;
        logic [VW-1:0] num_val;
    } t_tok;

    typedef struct packed {
        t_event        ev_code;
        logic [VW-1:0] value;
    } t_res;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    // Digit value in base 36; 36 for anything else
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return 6'(c - 8'h30);
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            return 6'(c - 8'h61) + 6'd10;
        end
        if (c >= 8'h41 && c <= 8'h5A) begin
            return 6'(c - 8'h41) + 6'd10;
        end
        return 6'd36;
    endfunction

endpackage

// ===== rtl/scp_front.sv =====
module scp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_char_code,
    input  logic            i_tokq_full,
    output logic            o_full,
    output logic            o_tok_push,
    output scp_pkg::t_tok   o_tok
);
    import scp_pkg::*;

    logic                r_in_token;
    logic [3:0]          r_len;
    logic [KW_COUNT-1:0] r_match;
    t_nphase             r_phase;
    t_nphase             n_phase;
    logic [VW-1:0]       r_acc;
    logic                r_neg;
    logic                r_dig;
    logic                r_ovf;

    logic                w_accept;
    logic                w_delim;
    logic [7:0]          w_upper;
    logic [5:0]          w_digit;
    logic [KW_COUNT-1:0] w_keep;
    logic [KW_COUNT-1:0] w_hit;
    logic                w_do_acc;
    t_base               w_base;
    logic                w_set_neg;
    logic                w_set_dig;
    logic                w_ws;
    logic [VW+4:0]       w_acc_x;
    logic [VW+4:0]       w_prod;
    logic                w_sat;
    logic [VW-1:0]       w_val;

    assign o_full   = i_tokq_full;
    assign w_accept = i_push && !i_tokq_full;
    assign w_delim  = (i_char_code == CH_SPACE) || (i_char_code == CH_LF)
                      || (i_char_code == CH_NUL);
    assign w_upper  = to_upper(i_char_code);
    assign w_digit  = digit_of(i_char_code);
    assign w_ws     = (i_char_code == CH_TAB) || (i_char_code == CH_VT)
                      || (i_char_code == CH_FF) || (i_char_code == CH_CR);

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            w_keep[k] = (r_len < KW_LEN[k]) && (KW_TEXT[k][r_len[2:0]] == w_upper);
            w_hit[k]  = r_match[k] && (r_len == KW_LEN[k]);
        end
    end

    // Number reader: next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_START, PH_SIGN: begin
                if (r_phase == PH_START && w_ws) begin
                    n_phase = PH_START;
                end else if (r_phase == PH_START
                             && (i_char_code == CH_PLUS || i_char_code == CH_MINUS)) begin
                    n_phase = PH_SIGN;
                end else if (i_char_code == CH_ZERO) begin
                    n_phase = PH_ZERO;
                end else if (w_digit < 6'd10) begin
                    n_phase = PH_DEC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_ZERO: begin
                if (i_char_code == CH_X_LO || i_char_code == CH_X_UP) begin
                    n_phase = PH_HEXP;
                end else if (w_digit < 6'd8) begin
                    n_phase = PH_OCT;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_HEXP, PH_HEX: n_phase = (w_digit < 6'd16) ? PH_HEX : PH_DONE;
            PH_OCT:          n_phase = (w_digit < 6'd8)  ? PH_OCT : PH_DONE;
            PH_DEC:          n_phase = (w_digit < 6'd10) ? PH_DEC : PH_DONE;
            default:         n_phase = PH_DONE;
        endcase
    end

    // Number reader: datapath controls
    always_comb begin
        w_do_acc  = 1'b0;
        w_base    = BASE_10;
        w_set_neg = 1'b0;
        w_set_dig = 1'b0;
        case (r_phase)
            PH_START, PH_SIGN: begin
                if (r_phase == PH_START && w_ws) begin
                    w_do_acc = 1'b0;
                end else if (r_phase == PH_START
                             && (i_char_code == CH_PLUS || i_char_code == CH_MINUS)) begin
                    w_set_neg = (i_char_code == CH_MINUS);
                end else if (i_char_code == CH_ZERO) begin
                    w_set_dig = 1'b1;
                end else if (w_digit < 6'd10) begin
                    w_do_acc = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_char_code != CH_X_LO && i_char_code != CH_X_UP && w_digit < 6'd8) begin
                    w_do_acc = 1'b1;
                    w_base   = BASE_8;
                end
            end
            PH_HEXP, PH_HEX: begin
                w_do_acc = (w_digit < 6'd16);
                w_base   = BASE_16;
            end
            PH_OCT: begin
                w_do_acc = (w_digit < 6'd8);
                w_base   = BASE_8;
            end
            PH_DEC: begin
                w_do_acc = (w_digit < 6'd10);
            end
            default: w_do_acc = 1'b0;
        endcase
    end

    // acc * base + digit, checked against the magnitude limit
    assign w_acc_x = {5'b0, r_acc};
    always_comb begin
        case (w_base)
            BASE_8:  w_prod = (w_acc_x << 3) + {{(VW-1){1'b0}}, w_digit};
            BASE_16: w_prod = (w_acc_x << 4) + {{(VW-1){1'b0}}, w_digit};
            default: w_prod = (w_acc_x << 3) + (w_acc_x << 1) + {{(VW-1){1'b0}}, w_digit};
        endcase
    end
    assign w_sat = w_prod > {5'b0, VAL_MIN};

    // Saturate to the signed range; acc never exceeds the limit
    always_comb begin
        if (r_neg) begin
            w_val = (r_ovf || r_acc[VW-1]) ? VAL_MIN : (~r_acc + 1'b1);
        end else begin
            w_val = (r_ovf || r_acc[VW-1]) ? VAL_MAX : r_acc;
        end
    end

    assign o_tok_push    = w_accept && w_delim && r_in_token;
    assign o_tok.idn     = w_hit[KW_IDN];
    assign o_tok.measq   = w_hit[KW_MEASQ] || w_hit[KW_MQ];
    assign o_tok.set     = w_hit[KW_SET];
    assign o_tok.meas    = w_hit[KW_MEASR] || w_hit[KW_MS];
    assign o_tok.num     = r_dig;
    assign o_tok.num_val = w_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_token <= 1'b0;
            r_len      <= '0;
            r_match    <= '1;
            r_phase    <= PH_START;
            r_acc      <= '0;
            r_neg      <= 1'b0;
            r_dig      <= 1'b0;
            r_ovf      <= 1'b0;
        end else if (w_accept) begin
            if (w_delim) begin
                r_in_token <= 1'b0;
                r_len      <= '0;
                r_match    <= '1;
                r_phase    <= PH_START;
                r_acc      <= '0;
                r_neg      <= 1'b0;
                r_dig      <= 1'b0;
                r_ovf      <= 1'b0;
            end else begin
                r_in_token <= 1'b1;
                r_match    <= r_match & w_keep;
                if (r_len != 4'd15) begin
                    r_len <= r_len + 4'd1;
                end
                r_phase <= n_phase;
                if (w_set_neg) begin
                    r_neg <= 1'b1;
                end
                if (w_do_acc || w_set_dig) begin
                    r_dig <= 1'b1;
                end
                // hold the magnitude once saturated
                if (w_do_acc && !r_ovf) begin
                    if (w_sat) begin
                        r_ovf <= 1'b1;
                        r_acc <= VAL_MIN;
                    end else begin
                        r_acc <= w_prod[VW-1:0];
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/scp_tokq.sv =====
module scp_tokq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scp_pkg::t_tok i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output scp_pkg::t_tok o_data
);
    import scp_pkg::*;

    t_tok       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/scp_back.sv =====
module scp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  scp_pkg::t_tok i_tok,
    input  logic          i_tok_empty,
    output logic          o_tok_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output scp_pkg::t_res o_res
);
    import scp_pkg::*;

    t_gstate       r_gs;
    t_gstate       n_gs;
    logic [VW-1:0] r_mv;
    logic [VW-1:0] n_mv;
    t_res          r_oq [2];
    logic          r_owp;
    logic          r_orp;
    logic [1:0]    r_ocnt;

    logic          w_take;
    logic          w_emit;
    t_event        w_ev;
    logic          w_opush;
    logic          w_opop;
    logic          w_keyish;
    logic          w_load;

    assign w_take    = !i_tok_empty && (r_ocnt != 2'd2);
    assign o_tok_pop = w_take;
    assign w_keyish  = i_tok.set || i_tok.meas || i_tok.num;
    assign w_load    = (r_gs == GS_SET_MEAS) && i_tok.num && !i_tok.set && !i_tok.meas;

    // Grammar: next state
    always_comb begin
        n_gs = GS_IDLE;
        if (!i_tok.idn && !i_tok.measq && w_keyish) begin
            if (i_tok.set && r_gs == GS_IDLE) begin
                n_gs = GS_SET;
            end else if (i_tok.meas && r_gs == GS_SET) begin
                n_gs = GS_SET_MEAS;
            end
        end
    end

    // Grammar: event and stored value
    always_comb begin
        w_emit = 1'b1;
        w_ev   = EV_UNKNOWN;
        n_mv   = r_mv;
        if (i_tok.idn) begin
            w_ev = EV_IDN;
        end else if (i_tok.measq) begin
            w_ev = EV_MEAS_REPORT;
        end else if (w_keyish) begin
            if ((i_tok.set && r_gs == GS_IDLE) || (i_tok.meas && r_gs == GS_SET)) begin
                w_emit = 1'b0;
            end else if (w_load) begin
                w_ev = EV_MEAS_SET;
                n_mv = i_tok.num_val;
            end else begin
                w_ev = EV_SYNTAX;
            end
        end
    end

    assign w_opush = w_take && w_emit;
    assign w_opop  = i_pop && (r_ocnt != 2'd0);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_oq[r_owp] <= '{ev_code: w_ev, value: n_mv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs   <= GS_IDLE;
            r_mv   <= '0;
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (w_take) begin
                r_gs <= n_gs;
                r_mv <= n_mv;
            end
            if (w_opush) begin
                r_owp <= ~r_owp;
            end
            if (w_opop) begin
                r_orp <= ~r_orp;
            end
            case ({w_opush, w_opop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

endmodule

// ===== rtl/scpi_command_parser_unit.sv =====
// Byte-serial command token parser.
// Input channel: drive i_char_code with push; a beat moves at a clock edge with
// push high and full low. Space, line feed and NUL close a token; each closed
// token is classified (keyword or number) and run through the SET MEAS grammar.
// Result channel: while empty is low, o_event_res and o_value show the oldest
// result; pop takes it. Only closing delimiters can produce a result.
// Throughput: one byte per cycle sustained while full is low; the path runs through the
// front tokenizer, a two-entry token queue and the grammar stage.
// A closed token is registered in the token queue, its result in the result queue.
// When the consumer stalls, the two-entry result queue fills, the grammar stage
// holds, then the token queue fills and full rises; bytes inside a token are
// held as well until the token queue has room.
// Reset (synchronous, active low) empties both queues, clears the token under
// way, returns the grammar to idle and zeroes the stored measure value.
`include "assert_macros.svh"

module scpi_command_parser_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_char_code,
    output logic                        empty,
    input  logic                        pop,
    output logic [2:0]                  o_event_res,
    output logic signed [scp_pkg::VW-1:0] o_value
);
    import scp_pkg::*;

    t_tok w_tok_in;
    t_tok w_tok_out;
    t_res w_res;
    logic w_tok_push;
    logic w_tok_pop;
    logic w_tokq_full;
    logic w_tokq_empty;
    logic w_delim_beat;

    scp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char_code (i_char_code),
        .i_tokq_full (w_tokq_full),
        .o_full      (full),
        .o_tok_push  (w_tok_push),
        .o_tok       (w_tok_in)
    );

    scp_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_tok_push),
        .i_data  (w_tok_in),
        .i_pop   (w_tok_pop),
        .o_full  (w_tokq_full),
        .o_empty (w_tokq_empty),
        .o_data  (w_tok_out)
    );

    scp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (w_tok_out),
        .i_tok_empty (w_tokq_empty),
        .o_tok_pop   (w_tok_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (w_res)
    );

    assign o_event_res = w_res.ev_code;
    assign o_value     = w_res.value;

    assign w_delim_beat = push && !full
                          && (i_char_code == CH_SPACE || i_char_code == CH_LF
                              || i_char_code == CH_NUL);

    `SCP_ASSERT_IMPL(a_tok_from_delim, w_tok_push, w_delim_beat, "token pushed without a delimiter")
    `SCP_ASSERT_IMPL(a_tokq_no_overrun, w_tok_push, !w_tokq_full, "token queue overrun")
    `SCP_ASSERT_IMPL(a_tokq_no_underrun, w_tok_pop, !w_tokq_empty, "token queue underrun")
    `SCP_ASSERT_NEXT(a_tokq_fills, w_tok_push && w_tokq_empty, !w_tokq_empty, "token queue lost")

endmodule

// ===== tb/scpi_command_parser_monitor.sv =====
`timescale 1ns / 1ps

module scpi_command_parser_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  char_code,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  event_res,
    input  logic [31:0] value,
    output int          mismatches,
    output int          outstanding
);
    import scp_pkg::*;

    localparam logic [63:0] NUM_LIMIT = 64'h0000_0000_8000_0000;

    typedef struct packed {
        t_event      code;
        logic [31:0] value;
    } t_report;

    t_report     report_q[$];

    t_gstate     gram_state;
    logic [31:0] stored_value;
    logic        tok_open;
    logic [3:0]  tok_len;
    logic [5:0]  key_hits;
    t_nphase     num_phase;
    logic [63:0] magnitude;
    logic        neg_sign;
    logic        have_digit;
    logic        saturated;

    function automatic int key_len(input int k);
        case (k)
            KW_IDN:   return 5;
            KW_MEASQ: return 8;
            KW_MQ:    return 5;
            KW_MEASR: return 7;
            KW_MS:    return 4;
            default:  return 3;
        endcase
    endfunction

    function automatic logic [7:0] key_char(input int k, input int i);
        logic [63:0] w;
        case (k)
            KW_IDN:   w = 64'("*IDN?");
            KW_MEASQ: w = 64'("MEASURE?");
            KW_MQ:    w = 64'("MEAS?");
            KW_MEASR: w = 64'("MEASURE");
            KW_MS:    w = 64'("MEAS");
            default:  w = 64'("SET");
        endcase
        return w[(key_len(k) - 1 - i) * 8 +: 8];
    endfunction

    function automatic bit key_full(input int k);
        return key_hits[k] && (tok_len == key_len(k));
    endfunction

    task automatic clear_token();
        tok_open   = 1'b0;
        tok_len    = '0;
        key_hits   = '1;
        num_phase  = PH_START;
        magnitude  = '0;
        neg_sign   = 1'b0;
        have_digit = 1'b0;
        saturated  = 1'b0;
    endtask

    task automatic add_digit(input logic [5:0] d, input logic [4:0] radix);
        have_digit = 1'b1;
        if (saturated) begin
            return;
        end
        if (magnitude > (NUM_LIMIT - d) / radix) begin
            saturated = 1'b1;
            magnitude = NUM_LIMIT;
        end else begin
            magnitude = magnitude * radix + d;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        end
    endtask

    // Advance the parser by one byte; a closing delimiter may yield a report.
    task automatic parse_byte(input logic [7:0] c, output bit hit, output t_report rep);
        logic [7:0] u;
        logic [5:0] d;
        bit         is_set;
        bit         is_meas;
        bit         is_num;
        t_event     code;
        hit  = 1'b0;
        code = EV_IDN;
        rep  = '0;
        if (c == CH_SPACE || c == CH_LF || c == CH_NUL) begin
            if (!tok_open) begin
                return;
            end
            is_set  = key_full(KW_SET);
            is_meas = key_full(KW_MEASR) || key_full(KW_MS);
            is_num  = have_digit;
            hit     = 1'b1;
            if (key_full(KW_IDN)) begin
                code       = EV_IDN;
                gram_state = GS_IDLE;
            end else if (key_full(KW_MEASQ) || key_full(KW_MQ)) begin
                code       = EV_MEAS_REPORT;
                gram_state = GS_IDLE;
            end else if (is_set || is_meas || is_num) begin
                if (is_set && gram_state == GS_IDLE) begin
                    gram_state = GS_SET;
                    hit        = 1'b0;
                end else if (is_meas && gram_state == GS_SET) begin
                    gram_state = GS_SET_MEAS;
                    hit        = 1'b0;
                end else if (gram_state == GS_SET_MEAS && is_num && !is_set && !is_meas) begin
                    if (neg_sign) begin
                        if (saturated || magnitude >= NUM_LIMIT) begin
                            stored_value = VAL_MIN;
                        end else begin
                            stored_value = 32'd0 - magnitude[31:0];
                        end
                    end else if (saturated || magnitude > NUM_LIMIT - 1) begin
                        stored_value = VAL_MAX;
                    end else begin
                        stored_value = magnitude[31:0];
                    end
                    code       = EV_MEAS_SET;
                    gram_state = GS_IDLE;
                end else begin
                    code       = EV_SYNTAX;
                    gram_state = GS_IDLE;
                end
            end else begin
                code       = EV_UNKNOWN;
                gram_state = GS_IDLE;
            end
            clear_token();
            rep.code  = code;
            rep.value = stored_value;
            return;
        end

        tok_open = 1'b1;
        u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (tok_len >= key_len(k)) begin
                key_hits[k] = 1'b0;
            end else if (key_char(k, int'(tok_len)) != u) begin
                key_hits[k] = 1'b0;
            end
        end
        if (tok_len < 4'd15) begin
            tok_len++;
        end

        if (c >= "0" && c <= "9") begin
            d = 6'(c - "0");
        end else if (c >= "a" && c <= "z") begin
            d = 6'(c - "a") + 6'd10;
        end else if (c >= "A" && c <= "Z") begin
            d = 6'(c - "A") + 6'd10;
        end else begin
            d = 6'd36;
        end

        // Leading white space and a sign are taken only at the start of a number.
        if (num_phase == PH_START && (c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR)) begin
            num_phase = PH_START;
        end else if (num_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
            if (c == CH_MINUS) begin
                neg_sign = 1'b1;
            end
            num_phase = PH_SIGN;
        end else begin
            case (num_phase)
                PH_START, PH_SIGN: begin
                    if (c == CH_ZERO) begin
                        have_digit = 1'b1;
                        num_phase  = PH_ZERO;
                    end else if (d < 10) begin
                        add_digit(d, 5'd10);
                        num_phase = PH_DEC;
                    end else begin
                        num_phase = PH_DONE;
                    end
                end
                PH_ZERO: begin
                    if (c == CH_X_LO || c == CH_X_UP) begin
                        num_phase = PH_HEXP;
                    end else if (d < 8) begin
                        add_digit(d, 5'd8);
                        num_phase = PH_OCT;
                    end else begin
                        num_phase = PH_DONE;
                    end
                end
                PH_HEXP, PH_HEX: begin
                    if (d < 16) begin
                        add_digit(d, 5'd16);
                        num_phase = PH_HEX;
                    end else begin
                        num_phase = PH_DONE;
                    end
                end
                PH_OCT: begin
                    if (d < 8) begin
                        add_digit(d, 5'd8);
                    end else begin
                        num_phase = PH_DONE;
                    end
                end
                PH_DEC: begin
                    if (d < 10) begin
                        add_digit(d, 5'd10);
                    end else begin
                        num_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : sample
        t_report want;
        t_report rep;
        bit      hit;
        if (!i_rst_n) begin
            gram_state   = GS_IDLE;
            stored_value = '0;
            clear_token();
            report_q.delete();
        end else begin
            // Check the result beat before predicting from this edge's input beat.
            if (pop && !empty) begin
                if (report_q.size() == 0) begin
                    report_mismatch("result beat with nothing due", {29'd0, event_res}, '0);
                end else begin
                    want = report_q.pop_front();
                    if (event_res !== want.code) begin
                        report_mismatch("event_res", {29'd0, event_res}, {29'd0, want.code});
                    end
                    if (value !== want.value) begin
                        report_mismatch("value", value, want.value);
                    end
                end
            end
            if (push && !full) begin
                parse_byte(char_code, hit, rep);
                if (hit) begin
                    report_q.push_back(rep);
                end
            end
        end
        outstanding = report_q.size();
    end

endmodule

// ===== tb/tb_scpi_command_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_scpi_command_parser_unit;
    import scp_pkg::*;

    localparam int TOTAL_BYTES  = 1950;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [7:0]           i_char_code;
    logic                 empty;
    logic                 pop;
    logic [2:0]           o_event_res;
    logic signed [VW-1:0] o_value;

    int                   mismatches;
    int                   outstanding;
    logic [7:0]           byte_stream[$];

    scpi_command_parser_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_code (i_char_code),
        .empty       (empty),
        .pop         (pop),
        .o_event_res (o_event_res),
        .o_value     (o_value)
    );

    scpi_command_parser_monitor u_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .char_code   (i_char_code),
        .empty       (empty),
        .pop         (pop),
        .event_res   (o_event_res),
        .value       (o_value),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic add_byte(input logic [7:0] b);
        byte_stream.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            byte_stream.push_back(s[i]);
        end
    endtask

    // Push the first keep characters of s, letters in random case.
    task automatic add_mixed(input string s, input int keep);
        logic [7:0] c;
        for (int i = 0; i < keep; i++) begin
            c = s[i];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) begin
                c = c + 8'h20;
            end
            byte_stream.push_back(c);
        end
    endtask

    task automatic add_delims();
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1) begin
            case ($urandom_range(0, 2))
                0:       add_byte(CH_SPACE);
                1:       add_byte(CH_LF);
                default: add_byte(CH_NUL);
            endcase
        end
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_SPACE || b == CH_LF || b == CH_NUL);
        return b;
    endfunction

    function automatic string pick_keyword();
        case ($urandom_range(0, 5))
            0:       return "*IDN?";
            1:       return "MEASURE?";
            2:       return "MEAS?";
            3:       return "MEASURE";
            4:       return "MEAS";
            default: return "SET";
        endcase
    endfunction

    task automatic add_number();
        logic [7:0] v;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 3))
                    0:       add_byte(CH_TAB);
                    1:       add_byte(CH_VT);
                    2:       add_byte(CH_FF);
                    default: add_byte(CH_CR);
                endcase
            end
        end
        case ($urandom_range(0, 3))
            0:       add_byte(CH_PLUS);
            1:       add_byte(CH_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 4))
            0: begin
                add_byte(8'("1" + $urandom_range(0, 8)));
                repeat ($urandom_range(0, 11)) add_byte(8'("0" + $urandom_range(0, 9)));
            end
            1: begin
                add_byte(CH_ZERO);
                add_byte($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
                repeat ($urandom_range(0, 10)) begin
                    v = 8'($urandom_range(0, 15));
                    add_byte(8'(v < 10 ? "0" + v : ($urandom_range(0, 1) ? "a" : "A") + v - 10));
                end
            end
            2: begin
                add_byte(CH_ZERO);
                repeat ($urandom_range(0, 12)) add_byte(8'("0" + $urandom_range(0, 7)));
            end
            3: begin
                case ($urandom_range(0, 7))
                    0:       add_text("2147483647");
                    1:       add_text("2147483648");
                    2:       add_text("4294967295");
                    3:       add_text("0x7fffffff");
                    4:       add_text("0x80000000");
                    5:       add_text("0XFFFFFFFF");
                    6:       add_text("017777777777");
                    default: add_text("0");
                endcase
            end
            default: add_byte(8'("0" + $urandom_range(0, 9)));
        endcase
        if ($urandom_range(0, 7) == 0) begin
            add_byte(junk_byte());
        end
    endtask

    initial begin : stimulus
        int    r;
        int    burst_left;
        int    gap;
        int    n;
        string s;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_char_code = 8'h00;

        // directed commands
        add_text("*IDN? ");
        add_text("meas?\n");
        add_text("MeAsUrE?");
        add_byte(CH_NUL);
        add_text("   \n");
        add_text("SET MEAS 42 ");
        add_text("set measure -0x1F\n");
        add_text("SET MEAS 0x ");
        add_text("SET MEAS 2147483647 ");
        add_text("SET MEAS 99999999999 ");
        add_text("SET MEAS -2147483648 ");
        add_text("SET MEAS -0XFFFFFFFFF ");
        add_text("SET MEAS 0777 ");
        add_text("SET MEAS 12ab ");
        add_text("SET MEAS ");
        add_byte(CH_TAB);
        add_byte(CH_VT);
        add_byte(CH_FF);
        add_byte(CH_CR);
        add_text("+5 ");
        add_text("SET SET MEAS 3 ");
        add_text("7 MEAS FOO ");
        add_text("MEASUREMENTOVERFLOW1 ");
        add_byte(8'hFF);
        add_byte(8'h80);
        add_text(" SET *IDN? ");
        add_text("SET MEAS MEAS? ");
        add_text("SET MEAS -0 ");
        add_text("SET MEAS 08 ");
        add_text("SET MEAS + ");

        while (byte_stream.size() < TOTAL_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                add_mixed("SET", 3);
                add_delims();
                if ($urandom_range(0, 1)) begin
                    s = "MEAS";
                end else begin
                    s = "MEASURE";
                end
                add_mixed(s, s.len());
                add_delims();
                add_number();
            end else if (r < 45) begin
                add_mixed("*IDN?", 5);
            end else if (r < 55) begin
                if ($urandom_range(0, 1)) begin
                    s = "MEAS?";
                end else begin
                    s = "MEASURE?";
                end
                add_mixed(s, s.len());
            end else if (r < 65) begin
                // broken sequence: SET, maybe MEAS, then anything
                add_mixed("SET", 3);
                add_delims();
                if ($urandom_range(0, 1)) begin
                    add_mixed("MEAS", 4);
                    add_delims();
                end
                case ($urandom_range(0, 2))
                    0: add_number();
                    1: begin
                        s = pick_keyword();
                        add_mixed(s, s.len());
                    end
                    default: repeat ($urandom_range(1, 6)) add_byte(junk_byte());
                endcase
            end else if (r < 73) begin
                s = pick_keyword();
                add_mixed(s, s.len());
            end else if (r < 80) begin
                add_number();
            end else if (r < 86) begin
                repeat ($urandom_range(1, 20)) add_byte(junk_byte());
            end else if (r < 93) begin
                s = pick_keyword();
                if ($urandom_range(0, 1)) begin
                    add_mixed(s, s.len() - 1);
                end else begin
                    add_mixed(s, s.len());
                    add_byte(junk_byte());
                end
            end else begin
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            end
            add_delims();
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        n = byte_stream.size();
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
            push        <= 1'b1;
            i_char_code <= byte_stream[i];
            do @(posedge i_clk); while (full);
            @(negedge i_clk);
            burst_left--;
            if (burst_left == 0 && i + 1 < n) begin
                gap = $urandom_range(0, 12);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 40);
            end
        end
        push <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("scpi_command_parser_unit regression: pass");
        end else begin
            $display("scpi_command_parser_unit regression: fail");
        end
        $finish;
    end

    initial begin : consumer
        int taken;
        int cycle;
        int pct;
        int hold_idx;
        pop      = 1'b0;
        taken    = 0;
        cycle    = 0;
        pct      = 100;
        hold_idx = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            // hold off long enough for both internal queues to fill and full to rise
            if ((hold_idx == 0 && taken >= 20) || (hold_idx == 1 && taken >= 150)) begin
                pop <= 1'b0;
                hold_idx++;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (cycle % 64 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    pct = 100;
                    2:       pct = 60;
                    3:       pct = 30;
                    default: pct = 10;
                endcase
            end
            cycle++;
            pop <= ($urandom_range(1, 100) <= pct);
            @(posedge i_clk);
            if (pop && !empty) begin
                taken++;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("scpi_command_parser_unit regression: fail");
        $finish;
    end

endmodule
